/* rtl/prt_pkg.sv */
// prt_pkg: shared types, constants and the kind decoder of the port rule table.
// Used by prt_dp, prt_ctrl and port_rule_table; depends on nothing.
`timescale 1ns / 1ps
package prt_pkg;

	localparam int MAX_RULES_DEF = 32;
	localparam int FUNC_W   = 2;
	localparam int PORT_W   = 16;
	localparam int KIND_W   = 8;
	localparam int SLOT_W   = 5;
	localparam int STATUS_W = 3;
	localparam int TOTAL_W  = 6;
	localparam int CODE_W   = 2;
	localparam int ENTRY_W  = PORT_W + CODE_W;

	localparam logic [KIND_W-1:0] KIND_CH_IN  = 8'h49;
	localparam logic [KIND_W-1:0] KIND_CH_OUT = 8'h4F;
	localparam logic [KIND_W-1:0] KIND_CH_FWD = 8'h46;
	localparam logic [KIND_W-1:0] KIND_CH_PRX = 8'h50;

	localparam logic [CODE_W-1:0] KIND_IN  = 2'd0;
	localparam logic [CODE_W-1:0] KIND_OUT = 2'd1;
	localparam logic [CODE_W-1:0] KIND_FWD = 2'd2;
	localparam logic [CODE_W-1:0] KIND_PRX = 2'd3;

	typedef enum logic [FUNC_W-1:0] {
		FN_LOOKUP = 2'd0,
		FN_INSERT = 2'd1,
		FN_REMOVE = 2'd2,
		FN_NONE   = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_KIND  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_POS   = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		SEL_ZERO  = 2'd0,
		SEL_HIT   = 2'd1,
		SEL_COUNT = 2'd2,
		SEL_SLOT  = 2'd3
	} match_sel_t;

	typedef struct packed {
		logic              ok;
		logic [CODE_W-1:0] code;
	} kind_dec_t;

	typedef struct packed {
		logic       load;
		logic       rd;
		logic       shift;
		logic       append;
		logic       remove;
		logic       respond;
		status_t    status;
		match_sel_t sel;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  kind_ok;
		logic  slot_ok;
		logic  hit;
		logic  pend;
		logic  more;
		logic  full;
	} sts_t;

	function automatic kind_dec_t kind_decode(input logic [KIND_W-1:0] ch);
		kind_dec_t d;
		d.ok   = 1'b1;
		d.code = KIND_IN;
		case (ch)
			KIND_CH_IN:  d.code = KIND_IN;
			KIND_CH_OUT: d.code = KIND_OUT;
			KIND_CH_FWD: d.code = KIND_FWD;
			KIND_CH_PRX: d.code = KIND_PRX;
			default:     d.ok = 1'b0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/port_rule_table.sv */
// port_rule_table: ordered packet-filter port rule table, top level.
// Depends on prt_pkg, prt_ctrl, prt_dp and prt_ram.
//
// Usage:
//   Drive func, port, rule_kind and slot with start high; the transaction is
//   taken at a rising edge where start is high and busy is low. busy stays
//   high while the transaction is worked on.
//   Exactly one result follows each transaction: done is high for one cycle
//   with status, match_slot and rule_total valid in that cycle. The receiver
//   cannot stall; results must be taken when done is high.
//   Lookup and insert scan the stored rules one per cycle through the
//   registered RAM read port, stopping early on a match; an invalid kind or
//   bad position is answered from the dispatch state, without a scan.
//   Remove shifts the rules above the slot down one entry per cycle, one read
//   and one write per cycle.
//   A new transaction can be taken in the cycle its predecessor's result shows.
//   Reset empties the table (rule count zero); RAM contents are not cleared.
`timescale 1ns / 1ps
module port_rule_table #(
	parameter int MAX_RULES = prt_pkg::MAX_RULES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [prt_pkg::FUNC_W-1:0]    func,
	input  logic [prt_pkg::PORT_W-1:0]    port,
	input  logic [prt_pkg::KIND_W-1:0]    rule_kind,
	input  logic [prt_pkg::SLOT_W-1:0]    slot,
	output logic                          done,
	output logic [prt_pkg::STATUS_W-1:0]  status,
	output logic [prt_pkg::SLOT_W-1:0]    match_slot,
	output logic [prt_pkg::TOTAL_W-1:0]   rule_total
);
	import prt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	prt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.sts   (sts),
		.cmd   (cmd)
	);

	prt_dp #(
		.MAX_RULES(MAX_RULES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (func),
		.port      (port),
		.rule_kind (rule_kind),
		.slot      (slot),
		.done      (done),
		.status    (status),
		.match_slot(match_slot),
		.rule_total(rule_total)
	);

endmodule

/* rtl/prt_ram.sv */
// prt_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module prt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/prt_dp.sv */
// prt_dp: datapath of the port rule table: rule RAM, count, scan index, read stage
// and result registers. Depends on prt_pkg and prt_ram.
`timescale 1ns / 1ps
module prt_dp #(
	parameter int MAX_RULES = prt_pkg::MAX_RULES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  prt_pkg::cmd_t                 cmd,
	output prt_pkg::sts_t                 sts,
	input  logic [prt_pkg::FUNC_W-1:0]    func,
	input  logic [prt_pkg::PORT_W-1:0]    port,
	input  logic [prt_pkg::KIND_W-1:0]    rule_kind,
	input  logic [prt_pkg::SLOT_W-1:0]    slot,
	output logic                          done,
	output logic [prt_pkg::STATUS_W-1:0]  status,
	output logic [prt_pkg::SLOT_W-1:0]    match_slot,
	output logic [prt_pkg::TOTAL_W-1:0]   rule_total
);
	import prt_pkg::*;

	localparam int AW = $clog2(MAX_RULES);
	localparam int CW = $clog2(MAX_RULES + 1);
	localparam int WW = (CW > TOTAL_W) ? CW : TOTAL_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RULES);

	func_t               func_q;
	logic [PORT_W-1:0]   port_q;
	logic [CODE_W-1:0]   code_q;
	logic                kind_ok_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CW-1:0]       cnt_q;
	logic [CW-1:0]       idx_q;
	logic                rv_s1;
	logic [AW-1:0]       ridx_s1;
	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   match_q;
	logic [TOTAL_W-1:0]  total_q;

	kind_dec_t          kdec;
	logic               rd_go;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;
	logic [CW-1:0]      cnt_d;
	logic [CW-1:0]      idx_init;
	logic [WW-1:0]      slot_w;
	logic [WW-1:0]      cnt_w;
	logic [WW-1:0]      cnt_d_w;
	logic [WW-1:0]      match_w;

	assign kdec     = kind_decode(rule_kind);
	assign slot_w   = WW'(slot_q);
	assign cnt_w    = WW'(cnt_q);
	assign idx_init = CW'(WW'(slot) + WW'(1));

	assign sts.func    = func_q;
	assign sts.kind_ok = kind_ok_q;
	assign sts.slot_ok = slot_w < cnt_w;
	assign sts.hit     = rv_s1 && (rdata == {port_q, code_q});
	assign sts.pend    = rv_s1;
	assign sts.more    = idx_q < cnt_q;
	assign sts.full    = cnt_q == MAX_CNT;

	assign rd_go = cmd.rd && sts.more;
	assign we    = cmd.append || (cmd.shift && rv_s1);
	assign waddr = cmd.append ? cnt_q[AW-1:0] : ridx_s1 - AW'(1);
	assign wdata = cmd.append ? {port_q, code_q} : rdata;

	prt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_RULES)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_go),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		cnt_d = cnt_q;
		if (cmd.append) begin
			cnt_d = cnt_q + CW'(1);
		end else if (cmd.remove) begin
			cnt_d = cnt_q - CW'(1);
		end
	end
	assign cnt_d_w = WW'(cnt_d);

	always_comb begin
		case (cmd.sel)
			SEL_HIT:   match_w = WW'(ridx_s1);
			SEL_COUNT: match_w = cnt_w;
			SEL_SLOT:  match_w = slot_w;
			default:   match_w = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			rv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			rv_s1  <= rd_go;
			done_q <= cmd.respond;
			if (cmd.load) begin
				idx_q <= (func_t'(func) == FN_REMOVE) ? idx_init : '0;
			end else if (rd_go) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= func_t'(func);
			port_q    <= port;
			code_q    <= kdec.code;
			kind_ok_q <= kdec.ok;
			slot_q    <= slot;
		end
		if (rd_go) begin
			ridx_s1 <= idx_q[AW-1:0];
		end
		if (cmd.respond) begin
			status_q <= cmd.status;
			match_q  <= match_w[SLOT_W-1:0];
			total_q  <= cnt_d_w[TOTAL_W-1:0];
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign match_slot = match_q;
	assign rule_total = total_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MAX_CNT)
		else $error("rule count above table size");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");
	a_remove_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.remove |-> (cnt_q != '0))
		else $error("remove from empty table");

endmodule

/* rtl/prt_ctrl.sv */
// prt_ctrl: controller state machine of the port rule table; sequences scan,
// append and shift-down transactions. Depends on prt_pkg.
`timescale 1ns / 1ps
module prt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  prt_pkg::sts_t sts,
	output prt_pkg::cmd_t cmd
);
	import prt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.func)
					FN_LOOKUP, FN_INSERT: begin
						if (!sts.kind_ok) begin
							cmd.respond = 1'b1;
							cmd.sel     = SEL_ZERO;
							cmd.status  = (sts.func == FN_INSERT) ? ST_BAD_KIND : ST_NOT_FOUND;
							state_d     = S_IDLE;
						end else begin
							state_d = S_SCAN;
						end
					end
					FN_REMOVE: begin
						if (sts.slot_ok) begin
							state_d = S_SHIFT;
						end else begin
							cmd.respond = 1'b1;
							cmd.sel     = SEL_ZERO;
							cmd.status  = ST_BAD_POS;
							state_d     = S_IDLE;
						end
					end
					default: begin
						cmd.respond = 1'b1;
						cmd.sel     = SEL_ZERO;
						cmd.status  = ST_BAD_POS;
						state_d     = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.hit) begin
					cmd.respond = 1'b1;
					cmd.sel     = SEL_HIT;
					cmd.status  = (sts.func == FN_INSERT) ? ST_DUPLICATE : ST_OK;
					state_d     = S_IDLE;
				end else if (sts.more) begin
					cmd.rd = 1'b1;
				end else if (!sts.pend) begin
					cmd.respond = 1'b1;
					state_d     = S_IDLE;
					if (sts.func != FN_INSERT) begin
						cmd.sel    = SEL_ZERO;
						cmd.status = ST_NOT_FOUND;
					end else if (sts.full) begin
						cmd.sel    = SEL_ZERO;
						cmd.status = ST_FULL;
					end else begin
						cmd.append = 1'b1;
						cmd.sel    = SEL_COUNT;
						cmd.status = ST_OK;
					end
				end
			end
			S_SHIFT: begin
				cmd.shift = 1'b1;
				cmd.rd    = 1'b1;
				if (!sts.more && !sts.pend) begin
					cmd.remove  = 1'b1;
					cmd.respond = 1'b1;
					cmd.sel     = SEL_SLOT;
					cmd.status  = ST_OK;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != S_IDLE;

	a_respond_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |=> (state_q == S_IDLE))
		else $error("controller not idle after result");
	a_append_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.append |-> (!sts.full && !sts.hit && sts.kind_ok))
		else $error("append into full table or over a duplicate");

endmodule
